// ===== rtl/bounded_ordered_list_engine_assert.svh =====
// ----------------------------------------------------------------------------
// Bounded ordered list engine assertion macros
// Shared clocking and reset masking for the port-level checks.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_ORDERED_LIST_ENGINE_ASSERT_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, masked while reset is asserted.
`define BOLE_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define BOLE_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bole_pkg.sv =====
// ----------------------------------------------------------------------------
// Bounded ordered list engine package
// Field widths, operation and status codes, controller states, result beat.
// ----------------------------------------------------------------------------
package bole_pkg;

  localparam int unsigned DepthDefault = 32;
  localparam int unsigned DataW        = 32;
  localparam int unsigned ModeW        = 3;
  localparam int unsigned StatusW      = 3;
  localparam int unsigned CountOutW    = 6;

  typedef enum logic [ModeW-1:0] {
    MODE_APPEND    = 3'd0,
    MODE_DEL_FIRST = 3'd1,
    MODE_DEL_LAST  = 3'd2,
    MODE_DEL_KEY   = 3'd3,
    MODE_DISPLAY   = 3'd4
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE     = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_SHOW     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_LAST,
    S_EMIT,
    S_SHOW
  } ctrl_state_e;

  typedef struct packed {
    status_e                 status;
    logic signed [DataW-1:0] value;
    logic [CountOutW-1:0]    count;
    logic                    last;
  } res_t;

endpackage

// ===== rtl/bole_mem.sv =====
// ----------------------------------------------------------------------------
// Entry memory
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bole_mem #(
  parameter int unsigned DEPTH = bole_pkg::DepthDefault,
  parameter int unsigned WIDTH = bole_pkg::DataW,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [AddrW-1:0]        waddr_i,
  input  logic signed [WIDTH-1:0] wdata_i,
  input  logic                    re_i,
  input  logic [AddrW-1:0]        raddr_i,
  output logic signed [WIDTH-1:0] rdata_o
);

  logic signed [WIDTH-1:0] mem_q [DEPTH];
  logic signed [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Hold read data until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bole_ctrl.sv =====
// ----------------------------------------------------------------------------
// List controller
// Decodes operations, walks the entry memory for search, compaction and
// display, and hands result beats to the output register.
// ----------------------------------------------------------------------------
module bole_ctrl #(
  parameter int unsigned DEPTH = bole_pkg::DepthDefault,
  localparam int unsigned AddrW = $clog2(DEPTH),
  localparam int unsigned CntW  = $clog2(DEPTH + 1)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [bole_pkg::ModeW-1:0]       mode_i,
  input  logic signed [bole_pkg::DataW-1:0] value_i,
  input  logic                             slot_free_i,
  output logic                             push_o,
  output bole_pkg::res_t                   res_o,
  output logic                             mem_we_o,
  output logic [AddrW-1:0]                 mem_waddr_o,
  output logic signed [bole_pkg::DataW-1:0] mem_wdata_o,
  output logic                             mem_re_o,
  output logic [AddrW-1:0]                 mem_raddr_o,
  input  logic signed [bole_pkg::DataW-1:0] mem_rdata_i
);

  import bole_pkg::*;

  ctrl_state_e             state_q, state_d;
  logic [CntW-1:0]         count_q, count_d;
  logic [AddrW-1:0]        idx_q, idx_d;
  logic signed [DataW-1:0] key_q, key_d;
  logic                    any_q, any_d;
  logic signed [DataW-1:0] got_q, got_d;
  status_e                 status_q, status_d;
  logic                    dec_q, dec_d;

  logic                    accept;
  logic [CntW-1:0]         idx_next;
  logic                    more;
  logic                    hit;
  logic                    empty;
  logic                    full;

  assign in_stall_o = !((state_q == S_IDLE) && slot_free_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign idx_next   = CntW'(idx_q) + CntW'(1);
  assign more       = idx_next < count_q;
  assign hit        = any_q || (mem_rdata_i == key_q);
  assign empty      = (count_q == '0);
  assign full       = (count_q >= CntW'(DEPTH));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && !empty) begin
          unique case (mode_i)
            MODE_DEL_FIRST, MODE_DEL_KEY: state_d = S_SCAN;
            MODE_DEL_LAST:                state_d = S_LAST;
            MODE_DISPLAY:                 state_d = S_SHOW;
            default:                      state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_d = more ? S_SHIFT : S_EMIT;
        end else if (!more) begin
          state_d = S_EMIT;
        end
      end
      S_SHIFT: begin
        if (!more) begin
          state_d = S_EMIT;
        end
      end
      S_LAST: state_d = S_EMIT;
      S_EMIT: begin
        if (slot_free_i) begin
          state_d = S_IDLE;
        end
      end
      S_SHOW: begin
        if (slot_free_i && !more) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    count_d      = count_q;
    idx_d        = idx_q;
    key_d        = key_q;
    any_d        = any_q;
    got_d        = got_q;
    status_d     = status_q;
    dec_d        = dec_q;
    mem_we_o     = 1'b0;
    mem_waddr_o  = idx_q - AddrW'(1);
    mem_wdata_o  = mem_rdata_i;
    mem_re_o     = 1'b0;
    mem_raddr_o  = AddrW'(idx_next);
    push_o       = 1'b0;
    res_o.status = ST_DONE;
    res_o.value  = '0;
    res_o.count  = CountOutW'(count_q);
    res_o.last   = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          key_d = value_i;
          idx_d = '0;
          unique case (mode_i)
            MODE_APPEND: begin
              push_o = 1'b1;
              if (full) begin
                res_o.status = ST_FULL;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = AddrW'(count_q);
                mem_wdata_o = value_i;
                count_d     = count_q + CntW'(1);
                res_o.count = CountOutW'(count_q + CntW'(1));
              end
            end
            MODE_DEL_FIRST, MODE_DEL_LAST, MODE_DEL_KEY, MODE_DISPLAY: begin
              if (empty) begin
                push_o       = 1'b1;
                res_o.status = ST_EMPTY;
              end else begin
                // Start the first read; data arrives next cycle.
                mem_re_o    = 1'b1;
                mem_raddr_o = (mode_i == MODE_DEL_LAST) ? AddrW'(count_q - CntW'(1)) : '0;
                any_d       = (mode_i == MODE_DEL_FIRST);
              end
            end
            default: push_o = 1'b1;
          endcase
        end
      end
      S_SCAN: begin
        if (hit) begin
          got_d    = mem_rdata_i;
          status_d = ST_DONE;
          dec_d    = 1'b1;
        end else if (!more) begin
          got_d    = '0;
          status_d = ST_NOTFOUND;
          dec_d    = 1'b0;
        end
        if (more) begin
          mem_re_o = 1'b1;
          idx_d    = AddrW'(idx_next);
        end
      end
      S_SHIFT: begin
        // Move the entry just read one place toward the head.
        mem_we_o = 1'b1;
        if (more) begin
          mem_re_o = 1'b1;
          idx_d    = AddrW'(idx_next);
        end
      end
      S_LAST: begin
        got_d    = mem_rdata_i;
        status_d = ST_DONE;
        dec_d    = 1'b1;
      end
      S_EMIT: begin
        if (slot_free_i) begin
          push_o       = 1'b1;
          res_o.status = status_q;
          res_o.value  = got_q;
          if (dec_q) begin
            count_d     = count_q - CntW'(1);
            res_o.count = CountOutW'(count_q - CntW'(1));
          end
        end
      end
      S_SHOW: begin
        if (slot_free_i) begin
          push_o       = 1'b1;
          res_o.status = ST_SHOW;
          res_o.value  = mem_rdata_i;
          res_o.last   = !more;
          if (more) begin
            mem_re_o = 1'b1;
            idx_d    = AddrW'(idx_next);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    key_q    <= key_d;
    any_q    <= any_d;
    got_q    <= got_d;
    status_q <= status_d;
    dec_q    <= dec_d;
  end

endmodule

// ===== rtl/bounded_ordered_list_engine.sv =====
// ----------------------------------------------------------------------------
// Bounded ordered list engine
// Ordered list of up to DEPTH signed 32-bit values held in one entry memory.
// ----------------------------------------------------------------------------
// Each input beat carries one operation: append, delete first, delete last,
// delete by key, or display. Entries live head to tail at addresses 0 up to
// count-1 of a single-port-read, single-port-write memory with registered
// read data, so the controller walks the list through that one read port
// one entry at a time. Append, an undefined mode, and any operation on an
// empty list reply in the accept cycle. Delete last reads the tail, captures
// it, then replies. Delete first and delete by key walk the whole list
// whether the key is found or not: the scan reads up to the match, then
// every later entry is read and written back one address lower so the list
// stays packed, then the reply goes out. Display streams one entry beat per
// cycle while the output side keeps stall low, with last set on the tail
// entry. A new operation is taken only once the previous one has issued its
// final beat and the single output register can take the next reply, that
// is, when it is empty or its beat leaves in that same cycle; while a beat
// waits on a stalled receiver, the input stalls as well. The list is empty
// after reset and needs no clearing pass: entries at or beyond the count
// are never read.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine #(
  parameter int unsigned DEPTH = bole_pkg::DepthDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Operation channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [bole_pkg::ModeW-1:0]         mode_i,
  input  logic signed [bole_pkg::DataW-1:0]  value_i,
  // Result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [bole_pkg::StatusW-1:0]       status_o,
  output logic signed [bole_pkg::DataW-1:0]  result_value_o,
  output logic [bole_pkg::CountOutW-1:0]     entry_count_o,
  output logic                               last_o
);

  import bole_pkg::*;

  localparam int unsigned AddrW = $clog2(DEPTH);

  // Controller to memory
  logic                    mem_we;
  logic [AddrW-1:0]        mem_waddr;
  logic signed [DataW-1:0] mem_wdata;
  logic                    mem_re;
  logic [AddrW-1:0]        mem_raddr;
  logic signed [DataW-1:0] mem_rdata;

  // Controller to output register
  logic                    push;
  res_t                    res;
  logic                    slot_free;

  // Output register
  logic                    out_valid_q, out_valid_d;
  res_t                    out_res_q;

  bole_mem #(
    .DEPTH (DEPTH),
    .WIDTH (DataW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  bole_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .value_i     (value_i),
    .slot_free_i (slot_free),
    .push_o      (push),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // The slot frees up when it is empty or its beat leaves this cycle.
  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (push) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Load a new beat only when the controller pushes; hold it otherwise.
  always_ff @(posedge clk_i) begin
    if (push) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_res_q.status;
  assign result_value_o = out_res_q.value;
  assign entry_count_o  = out_res_q.count;
  assign last_o         = out_res_q.last;

endmodule

// ===== rtl/bole_chk.sv =====
// ----------------------------------------------------------------------------
// Bounded ordered list engine port checker
// Checks result beats seen on the top-level ports; bound to the top level.
// ----------------------------------------------------------------------------
`include "bounded_ordered_list_engine_assert.svh"

module bole_chk #(
  parameter int unsigned DEPTH = bole_pkg::DepthDefault
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic [bole_pkg::StatusW-1:0]       status_o,
  input logic signed [bole_pkg::DataW-1:0]  result_value_o,
  input logic [bole_pkg::CountOutW-1:0]     entry_count_o,
  input logic                               last_o
);

  import bole_pkg::*;

  logic                             show_ok;
  logic                             empty_ok;
  logic                             full_ok;
  logic                             stalled;
  logic [StatusW+DataW+CountOutW:0] out_beat;

  assign show_ok  = (status_o == ST_SHOW);
  assign empty_ok = last_o && (entry_count_o == '0) && (result_value_o == '0);
  assign full_ok  = last_o && (entry_count_o == CountOutW'(DEPTH)) && (result_value_o == '0);
  assign stalled  = out_valid_o && out_stall_i;
  assign out_beat = {status_o, result_value_o, entry_count_o, last_o};

  // Only display produces more than one beat per operation.
  `BOLE_IMPLY(a_multi_display, out_valid_o && !last_o, show_ok, "non-final beat not display")

  // An empty-list reply is a single beat with zero value and zero count.
  `BOLE_IMPLY(a_empty_reply, out_valid_o && status_o == ST_EMPTY, empty_ok, "bad empty reply")

  // A full reply reports the list at capacity.
  `BOLE_IMPLY(a_full_reply, out_valid_o && status_o == ST_FULL, full_ok, "bad full reply")

  // A stalled result beat holds.
  `BOLE_NEXT(a_hold_stalled, stalled, out_valid_o && $stable(out_beat), "stalled beat changed")

endmodule

bind bounded_ordered_list_engine bole_chk #(.DEPTH(DEPTH)) u_bole_chk (.*);
